// ===== design/hsv2rgb_pkg.sv =====
// Types and constants shared by the HSV to RGB pipeline.
package hsv2rgb_pkg;

    localparam logic [8:0]  FULL_TURN  = 9'd360;
    localparam logic [5:0]  SECTOR_DEG = 6'd60;
    localparam logic [7:0]  UNIT       = 8'd255;
    // 255 * 60: full scale of a term before scaling by value
    localparam logic [13:0] DEN        = 14'd15300;
    localparam logic [21:0] DEN_HALF   = 22'd7650;
    // floor(n / 3825) = (n * RECIP) >> RECIP_SHIFT, exact for n < 2^20
    localparam logic [20:0] RECIP       = 21'd1122868;
    localparam int          RECIP_SHIFT = 32;

    localparam logic [2:0] SEC_0 = 3'd0;
    localparam logic [2:0] SEC_1 = 3'd1;
    localparam logic [2:0] SEC_2 = 3'd2;
    localparam logic [2:0] SEC_3 = 3'd3;
    localparam logic [2:0] SEC_4 = 3'd4;
    localparam logic [2:0] SEC_5 = 3'd5;

    typedef struct packed {
        logic [8:0] hue_degrees;
        logic [7:0] saturation;
        logic [7:0] brightness;
        logic [7:0] alpha_in;
    } t_hsv_in;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha_out;
    } t_rgb_out;

    typedef struct packed {
        logic [2:0] sector;
        logic [5:0] rem;
        logic [7:0] sat;
        logic [7:0] val;
        logic [7:0] alpha;
    } t_sect;

    typedef struct packed {
        logic [2:0]  sector;
        logic [7:0]  val;
        logic [7:0]  alpha;
        logic [13:0] term_p;
        logic [13:0] term_q;
        logic [13:0] term_t;
    } t_terms;

    typedef struct packed {
        logic [2:0]  sector;
        logic [7:0]  val;
        logic [7:0]  alpha;
        logic [21:0] num_p;
        logic [21:0] num_q;
        logic [21:0] num_t;
    } t_nums;

    typedef struct packed {
        logic [2:0] sector;
        logic [7:0] val;
        logic [7:0] alpha;
        logic [7:0] chan_p;
        logic [7:0] chan_q;
        logic [7:0] chan_t;
    } t_chans;

endpackage

// ===== design/hsv2rgb_sector.sv =====
// Stage 1: wrap the hue and split it into sector and remainder.
module hsv2rgb_sector (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  hsv2rgb_pkg::t_hsv_in  i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output hsv2rgb_pkg::t_sect    o_data
);

    logic               r_valid;
    hsv2rgb_pkg::t_sect r_data;
    hsv2rgb_pkg::t_sect n_data;
    logic [8:0]         hue_w;
    logic [8:0]         base;
    logic [2:0]         sec;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        hue_w = i_data.hue_degrees;
        if (i_data.hue_degrees >= hsv2rgb_pkg::FULL_TURN) begin
            hue_w = i_data.hue_degrees - hsv2rgb_pkg::FULL_TURN;
        end
        if (hue_w >= 9'(5 * hsv2rgb_pkg::SECTOR_DEG)) begin
            sec  = hsv2rgb_pkg::SEC_5;
            base = 9'(5 * hsv2rgb_pkg::SECTOR_DEG);
        end else if (hue_w >= 9'(4 * hsv2rgb_pkg::SECTOR_DEG)) begin
            sec  = hsv2rgb_pkg::SEC_4;
            base = 9'(4 * hsv2rgb_pkg::SECTOR_DEG);
        end else if (hue_w >= 9'(3 * hsv2rgb_pkg::SECTOR_DEG)) begin
            sec  = hsv2rgb_pkg::SEC_3;
            base = 9'(3 * hsv2rgb_pkg::SECTOR_DEG);
        end else if (hue_w >= 9'(2 * hsv2rgb_pkg::SECTOR_DEG)) begin
            sec  = hsv2rgb_pkg::SEC_2;
            base = 9'(2 * hsv2rgb_pkg::SECTOR_DEG);
        end else if (hue_w >= 9'(hsv2rgb_pkg::SECTOR_DEG)) begin
            sec  = hsv2rgb_pkg::SEC_1;
            base = 9'(hsv2rgb_pkg::SECTOR_DEG);
        end else begin
            sec  = hsv2rgb_pkg::SEC_0;
            base = 9'd0;
        end
        n_data.sector = sec;
        n_data.rem    = 6'(hue_w - base);
        n_data.sat    = i_data.saturation;
        n_data.val    = i_data.brightness;
        n_data.alpha  = i_data.alpha_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

endmodule

// ===== design/hsv2rgb_terms.sv =====
// Stage 2: form the saturation terms of p, q and t, in units of 1/15300.
module hsv2rgb_terms (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  hsv2rgb_pkg::t_sect  i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output hsv2rgb_pkg::t_terms o_data
);

    logic                r_valid;
    hsv2rgb_pkg::t_terms r_data;
    hsv2rgb_pkg::t_terms n_data;
    logic [13:0]         s_rem;
    logic [13:0]         s_comp;
    logic [5:0]          rem_comp;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        rem_comp       = hsv2rgb_pkg::SECTOR_DEG - i_data.rem;
        s_rem          = 14'(i_data.sat) * 14'(i_data.rem);
        s_comp         = 14'(i_data.sat) * 14'(rem_comp);
        n_data.sector  = i_data.sector;
        n_data.val     = i_data.val;
        n_data.alpha   = i_data.alpha;
        n_data.term_p  = 14'(hsv2rgb_pkg::UNIT - i_data.sat)
                         * 14'(hsv2rgb_pkg::SECTOR_DEG);
        n_data.term_q  = hsv2rgb_pkg::DEN - s_rem;
        n_data.term_t  = hsv2rgb_pkg::DEN - s_comp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

endmodule

// ===== design/hsv2rgb_numer.sv =====
// Stage 3: scale each term by value and add the rounding half.
module hsv2rgb_numer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  hsv2rgb_pkg::t_terms i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output hsv2rgb_pkg::t_nums  o_data
);

    logic               r_valid;
    hsv2rgb_pkg::t_nums r_data;
    hsv2rgb_pkg::t_nums n_data;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        n_data.sector = i_data.sector;
        n_data.val    = i_data.val;
        n_data.alpha  = i_data.alpha;
        n_data.num_p  = 22'(i_data.val) * 22'(i_data.term_p) + hsv2rgb_pkg::DEN_HALF;
        n_data.num_q  = 22'(i_data.val) * 22'(i_data.term_q) + hsv2rgb_pkg::DEN_HALF;
        n_data.num_t  = 22'(i_data.val) * 22'(i_data.term_t) + hsv2rgb_pkg::DEN_HALF;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

endmodule

// ===== design/hsv2rgb_div.sv =====
// Stage 4: divide each numerator by 15300 through a reciprocal multiply.
module hsv2rgb_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  hsv2rgb_pkg::t_nums  i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output hsv2rgb_pkg::t_chans o_data
);

    logic                r_valid;
    hsv2rgb_pkg::t_chans r_data;
    hsv2rgb_pkg::t_chans n_data;

    // 15300 = 4 * 3825: drop the factor of four, then multiply by 1/3825
    function automatic logic [7:0] div_den(input logic [21:0] num);
        logic [40:0] prod;
        prod = 41'(num[21:2]) * 41'(hsv2rgb_pkg::RECIP);
        return prod[hsv2rgb_pkg::RECIP_SHIFT +: 8];
    endfunction

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        n_data.sector = i_data.sector;
        n_data.val    = i_data.val;
        n_data.alpha  = i_data.alpha;
        n_data.chan_p = div_den(i_data.num_p);
        n_data.chan_q = div_den(i_data.num_q);
        n_data.chan_t = div_den(i_data.num_t);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

endmodule

// ===== design/hsv_to_rgb_converter.sv =====
// Top level of the HSV to RGB converter: four arithmetic stages and the channel router.
//
// Input channel i_valid/o_ready carries one pixel per transfer: hue in whole
// degrees (values 360 and above wrap by one turn), saturation, value and alpha.
// Output channel o_valid/i_ready carries red, green, blue and the unchanged alpha.
//
// Five register stages: sector split, saturation terms, value scaling,
// reciprocal divide by 15300, and routing of v, p, q, t by sector into the
// output register, which drives o_valid and o_data.
// Throughput is one pixel per clock while the receiver keeps i_ready high;
// the three multiply stages set the depth.
//
// Each stage holds its own valid bit and is ready whenever it is empty or its
// successor is ready, so bubbles close up while the receiver stalls.
// When i_ready is low the pipeline fills and holds; nothing is dropped or repeated.
// Synchronous active-low reset empties every stage; o_valid is low after reset
// and the block accepts input in the first cycle after reset is released.
module hsv_to_rgb_converter (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  hsv2rgb_pkg::t_hsv_in    i_data,
    output logic                    o_valid,
    input  logic                    i_ready,
    output hsv2rgb_pkg::t_rgb_out   o_data
);

    logic                  sect_valid, sect_ready;
    hsv2rgb_pkg::t_sect    sect_data;
    logic                  terms_valid, terms_ready;
    hsv2rgb_pkg::t_terms   terms_data;
    logic                  nums_valid, nums_ready;
    hsv2rgb_pkg::t_nums    nums_data;
    logic                  chans_valid, chans_ready;
    hsv2rgb_pkg::t_chans   chans_data;

    logic                  r_valid;
    hsv2rgb_pkg::t_rgb_out r_data;
    hsv2rgb_pkg::t_rgb_out n_data;

    hsv2rgb_sector u_sector (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (sect_valid),
        .i_ready (sect_ready),
        .o_data  (sect_data)
    );

    hsv2rgb_terms u_terms (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sect_valid),
        .o_ready (sect_ready),
        .i_data  (sect_data),
        .o_valid (terms_valid),
        .i_ready (terms_ready),
        .o_data  (terms_data)
    );

    hsv2rgb_numer u_numer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (terms_valid),
        .o_ready (terms_ready),
        .i_data  (terms_data),
        .o_valid (nums_valid),
        .i_ready (nums_ready),
        .o_data  (nums_data)
    );

    hsv2rgb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (nums_valid),
        .o_ready (nums_ready),
        .i_data  (nums_data),
        .o_valid (chans_valid),
        .i_ready (chans_ready),
        .o_data  (chans_data)
    );

    assign chans_ready = !r_valid || i_ready;
    assign o_valid     = r_valid;
    assign o_data      = r_data;

    // route v, p, q and t to the channels by sector
    always_comb begin
        n_data.alpha_out = chans_data.alpha;
        case (chans_data.sector)
            hsv2rgb_pkg::SEC_1: begin
                n_data.red   = chans_data.chan_q;
                n_data.green = chans_data.val;
                n_data.blue  = chans_data.chan_p;
            end
            hsv2rgb_pkg::SEC_2: begin
                n_data.red   = chans_data.chan_p;
                n_data.green = chans_data.val;
                n_data.blue  = chans_data.chan_t;
            end
            hsv2rgb_pkg::SEC_3: begin
                n_data.red   = chans_data.chan_p;
                n_data.green = chans_data.chan_q;
                n_data.blue  = chans_data.val;
            end
            hsv2rgb_pkg::SEC_4: begin
                n_data.red   = chans_data.chan_t;
                n_data.green = chans_data.chan_p;
                n_data.blue  = chans_data.val;
            end
            hsv2rgb_pkg::SEC_5: begin
                n_data.red   = chans_data.val;
                n_data.green = chans_data.chan_p;
                n_data.blue  = chans_data.chan_q;
            end
            default: begin
                n_data.red   = chans_data.val;
                n_data.green = chans_data.chan_t;
                n_data.blue  = chans_data.chan_p;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (chans_ready) begin
            r_valid <= chans_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (chans_valid && chans_ready) begin
            r_data <= n_data;
        end
    end

endmodule

// ===== bench/hsv_to_rgb_checker.sv =====
// Scoreboard for the HSV to RGB converter: predicts each pixel and compares the output transfers.
module hsv_to_rgb_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  hsv2rgb_pkg::t_hsv_in  i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  hsv2rgb_pkg::t_rgb_out i_out_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned TURN_DEG = hsv2rgb_pkg::FULL_TURN;
    localparam int unsigned SECT_DEG = hsv2rgb_pkg::SECTOR_DEG;
    localparam int unsigned FULL     = hsv2rgb_pkg::UNIT;
    localparam int unsigned SCALE    = hsv2rgb_pkg::DEN;
    localparam int          MAX_SHOWN = 10;

    hsv2rgb_pkg::t_rgb_out expected_rgb[$];
    int                    mismatches = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic int unsigned round_scaled(input int unsigned num);
        return (num + SCALE / 2) / SCALE;
    endfunction

    function automatic hsv2rgb_pkg::t_rgb_out convert_pixel(input hsv2rgb_pkg::t_hsv_in px);
        int unsigned           hue, frac, s, v, p, q, t;
        logic [2:0]            sector;
        hsv2rgb_pkg::t_rgb_out res;
        hue = px.hue_degrees;
        s   = px.saturation;
        v   = px.brightness;
        // wrap anything from a full turn upwards back onto the circle
        if (hue >= TURN_DEG)
            hue = hue - TURN_DEG;
        sector = 3'(hue / SECT_DEG);
        frac   = hue % SECT_DEG;
        p = round_scaled(v * (FULL - s) * SECT_DEG);
        q = round_scaled(v * (SCALE - s * frac));
        t = round_scaled(v * (SCALE - s * (SECT_DEG - frac)));
        case (sector)
            hsv2rgb_pkg::SEC_1: begin
                res.red = 8'(q); res.green = 8'(v); res.blue = 8'(p);
            end
            hsv2rgb_pkg::SEC_2: begin
                res.red = 8'(p); res.green = 8'(v); res.blue = 8'(t);
            end
            hsv2rgb_pkg::SEC_3: begin
                res.red = 8'(p); res.green = 8'(q); res.blue = 8'(v);
            end
            hsv2rgb_pkg::SEC_4: begin
                res.red = 8'(t); res.green = 8'(p); res.blue = 8'(v);
            end
            hsv2rgb_pkg::SEC_5: begin
                res.red = 8'(v); res.green = 8'(p); res.blue = 8'(q);
            end
            default: begin
                res.red = 8'(v); res.green = 8'(t); res.blue = 8'(p);
            end
        endcase
        res.alpha_out = px.alpha_in;
        return res;
    endfunction

    always @(posedge i_clk) begin
        hsv2rgb_pkg::t_rgb_out want;
        bit                    bad;
        if (i_rst_n) begin
            // check the output transfer before queueing this edge's input
            if (i_out_valid && i_out_ready) begin
                if (expected_rgb.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= MAX_SHOWN)
                        $display("%0t: unexpected pixel r=%0d g=%0d b=%0d a=%0d", $realtime,
                                 i_out_data.red, i_out_data.green, i_out_data.blue,
                                 i_out_data.alpha_out);
                end else begin
                    want = expected_rgb.pop_front();
                    bad  = (i_out_data.red !== want.red) || (i_out_data.green !== want.green) ||
                           (i_out_data.blue !== want.blue) ||
                           (i_out_data.alpha_out !== want.alpha_out);
                    if (bad) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= MAX_SHOWN)
                            $display({"%0t: pixel mismatch exp r=%0d g=%0d b=%0d a=%0d",
                                      " got r=%0d g=%0d b=%0d a=%0d"},
                                     $realtime, want.red, want.green, want.blue, want.alpha_out,
                                     i_out_data.red, i_out_data.green, i_out_data.blue,
                                     i_out_data.alpha_out);
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                expected_rgb.push_back(convert_pixel(i_in_data));
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_rgb.size();
    end

endmodule

// ===== bench/tb_hsv_to_rgb_converter.sv =====
// Testbench top for the HSV to RGB converter: clock, reset, pixel stimulus, receiver and verdict.
module tb_hsv_to_rgb_converter;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_PER_PHASE = 235;
    localparam int HOLD_CYCLES      = 60;
    localparam int TAIL_CYCLES      = 12;
    localparam int STUCK_LIMIT      = 3000;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    hsv2rgb_pkg::t_hsv_in  i_data  = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    hsv2rgb_pkg::t_rgb_out o_data;

    int fail_count;
    int pending;
    int tx_idle_pct = 16;
    int rx_idle_pct = 63;
    int hold_req    = 0;
    int hold_seen   = 0;
    int hold_left   = 0;
    int stuck_cycles = 0;

    always #6 i_clk = ~i_clk;

    hsv_to_rgb_converter DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    hsv_to_rgb_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_in_data    (i_data),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_out_data   (o_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // receiver: random back-pressure, plus a long hold-off whenever one is requested
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    function automatic hsv2rgb_pkg::t_hsv_in make_pixel(input int hue, input int s, input int v,
                                                        input int a);
        hsv2rgb_pkg::t_hsv_in px;
        px.hue_degrees = 9'(hue);
        px.saturation  = 8'(s);
        px.brightness  = 8'(v);
        px.alpha_in    = 8'(a);
        return px;
    endfunction

    function automatic int pick_level();
        int roll;
        roll = $urandom_range(99);
        if (roll < 8)
            return 0;
        if (roll < 16)
            return 255;
        return $urandom_range(255);
    endfunction

    function automatic hsv2rgb_pkg::t_hsv_in random_pixel();
        int roll, hue;
        roll = $urandom_range(99);
        if (roll < 80)
            hue = $urandom_range(360);
        else if (roll < 92)
            hue = $urandom_range(511, 361);
        else
            // land on or next to a sector boundary
            hue = 60 * $urandom_range(6) + $urandom_range(1) - $urandom_range(1);
        if (hue < 0)
            hue = 0;
        return make_pixel(hue, pick_level(), pick_level(), $urandom_range(255));
    endfunction

    // offer one pixel, with optional idle cycles first; return at the accepting edge
    task automatic send_pixel(input hsv2rgb_pkg::t_hsv_in px);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= px;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    task automatic random_phase(input int tx_pct, input int rx_pct, input bit with_hold);
        tx_idle_pct = tx_pct;
        rx_idle_pct <= rx_pct;
        if (with_hold)
            hold_req <= hold_req + 1;
        repeat (RANDOM_PER_PHASE)
            send_pixel(random_pixel());
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: each sector, its edges, the wrap-around hues and level extremes
        send_pixel(make_pixel(0,   255, 255, 0));
        send_pixel(make_pixel(59,  255, 255, 255));
        send_pixel(make_pixel(60,  255, 255, 1));
        send_pixel(make_pixel(119, 200, 180, 128));
        send_pixel(make_pixel(120, 255, 255, 64));
        send_pixel(make_pixel(179, 128, 255, 32));
        send_pixel(make_pixel(180, 255, 200, 16));
        send_pixel(make_pixel(239, 255, 255, 8));
        send_pixel(make_pixel(240, 100, 255, 4));
        send_pixel(make_pixel(299, 255, 77, 2));
        send_pixel(make_pixel(300, 255, 255, 170));
        send_pixel(make_pixel(359, 255, 255, 85));
        send_pixel(make_pixel(360, 255, 255, 255));
        send_pixel(make_pixel(361, 255, 255, 0));
        send_pixel(make_pixel(419, 180, 220, 99));
        send_pixel(make_pixel(511, 255, 255, 200));
        send_pixel(make_pixel(450, 1, 254, 127));
        send_pixel(make_pixel(30,  0,   255, 255));
        send_pixel(make_pixel(210, 255, 0,   0));
        send_pixel(make_pixel(90,  0,   0,   0));
        send_pixel(make_pixel(330, 255, 255, 255));
        send_pixel(make_pixel(150, 127, 128, 170));

        // hold the sender until every pixel so far has come out
        drain_results();

        random_phase(16, 63, 1'b1);
        random_phase(63, 16, 1'b0);
        random_phase(0,  0,  1'b1);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
